// File: src/matrix_inverse_4x4_unit_defines.svh
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_unit_defines
// assertion macros shared by the matrix inverse block
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_4X4_UNIT_DEFINES_SVH
`define MATRIX_INVERSE_4X4_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define MI4_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mi4 assertion failed");

// next-cycle implication, held off during reset
`define MI4_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mi4 assertion failed");

`endif

// File: src/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg
// shared constants, command/status types and permutation tables
// ----------------------------------------------------------------------------
`default_nettype none

package mi4_pkg;

  localparam int ELEM_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int ADDR_W     = 4;
  localparam int PROD_W     = 3 * ELEM_WIDTH;       // triple product
  localparam int MINOR_W    = PROD_W + 1;           // sum of six products
  localparam int DPROD_W    = MINOR_W + ELEM_WIDTH;
  localparam int DET_W      = DPROD_W + 1;
  localparam int MAG_W      = 64;
  localparam int SHIFT      = 2 * FRAC_BITS + 1;    // scale plus rounding bit
  localparam int NUM_W      = PROD_W + SHIFT + 1;
  localparam int DEN_W      = MAG_W + 1;
  localparam int Q_W        = ELEM_WIDTH + 1;
  localparam int DIV_STEPS  = NUM_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_FIRST = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_ACC   = 4'd3;
  localparam logic [3:0] OP_DMUL  = 4'd4;
  localparam logic [3:0] OP_DACC  = 4'd5;
  localparam logic [3:0] OP_DFIN  = 4'd6;
  localparam logic [3:0] OP_DIV   = 4'd7;
  localparam logic [3:0] OP_SING  = 4'd8;

  typedef struct packed {
    logic [3:0]        op;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              neg;
    logic              first;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic out_done;
  } status_t;

  // column picked in row i by term t of the 3x3 expansion
  function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] i);
    logic [5:0] cols;
    unique case (t)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd1, 2'd2, 2'd0};
      3'd2:    cols = {2'd2, 2'd0, 2'd1};
      3'd3:    cols = {2'd0, 2'd2, 2'd1};
      3'd4:    cols = {2'd1, 2'd0, 2'd2};
      default: cols = {2'd0, 2'd1, 2'd2};
    endcase
    return cols[{i, 1'b0} +: 2];
  endfunction

  // odd permutations
  function automatic logic perm_neg(input logic [2:0] t);
    return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
  endfunction

endpackage

`default_nettype wire

// File: src/mi4_ram.sv
// ----------------------------------------------------------------------------
// mi4_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/mi4_ctrl.sv
// ----------------------------------------------------------------------------
// mi4_ctrl
// sequencer: element load, determinant expansion, per-element cofactors
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire mi4_pkg::status_t status,
  output mi4_pkg::cmd_t        cmd
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_MINOR = 4'd1;
  localparam logic [3:0] S_DMUL  = 4'd2;
  localparam logic [3:0] S_DACC  = 4'd3;
  localparam logic [3:0] S_DFIN  = 4'd4;
  localparam logic [3:0] S_DWAIT = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_SING  = 4'd8;
  localparam logic [3:0] S_OUTW  = 4'd9;

  logic [3:0] state, state_next;
  logic [3:0] load_cnt, load_cnt_next;
  logic [2:0] term, term_next;
  logic [1:0] step, step_next;
  logic [1:0] dcol, dcol_next;
  logic [3:0] kidx, kidx_next;
  logic       det_mode, det_mode_next;

  logic [1:0] sr, sc, pj, row, col;

  always_comb begin
    sr  = det_mode ? 2'd0 : kidx[1:0];
    sc  = det_mode ? dcol : kidx[3:2];
    row = (step >= sr) ? step + 2'd1 : step;
    pj  = mi4_pkg::perm_col(term, step);
    col = (pj >= sc) ? pj + 2'd1 : pj;
  end

  always_comb begin
    state_next    = state;
    load_cnt_next = load_cnt;
    term_next     = term;
    step_next     = step;
    dcol_next     = dcol;
    kidx_next     = kidx;
    det_mode_next = det_mode;
    s_tready      = 1'b0;
    cmd.op        = mi4_pkg::OP_NOP;
    cmd.raddr     = '0;
    cmd.we        = 1'b0;
    cmd.waddr     = load_cnt;
    cmd.neg       = 1'b0;
    cmd.first     = 1'b0;
    cmd.last      = 1'b0;
    unique case (state)
      S_LOAD: begin
        s_tready = 1'b1;
        cmd.we   = s_tvalid;
        if (s_tvalid) begin
          load_cnt_next = load_cnt + 4'd1;
          if (load_cnt == 4'd15) begin
            det_mode_next = 1'b1;
            dcol_next     = 2'd0;
            term_next     = 3'd0;
            step_next     = 2'd0;
            state_next    = S_MINOR;
          end
        end
      end
      S_MINOR: begin
        if (step == 2'd3) begin
          cmd.op    = mi4_pkg::OP_ACC;
          cmd.neg   = mi4_pkg::perm_neg(term);
          cmd.first = (term == 3'd0);
          step_next = 2'd0;
          if (term == 3'd5) begin
            term_next  = 3'd0;
            state_next = det_mode ? S_DMUL : S_DIV;
          end else begin
            term_next = term + 3'd1;
          end
        end else begin
          cmd.op    = (step == 2'd0) ? mi4_pkg::OP_FIRST : mi4_pkg::OP_MUL;
          cmd.raddr = {row, col};
          step_next = step + 2'd1;
        end
      end
      S_DMUL: begin
        cmd.op     = mi4_pkg::OP_DMUL;
        cmd.raddr  = {2'd0, dcol};
        state_next = S_DACC;
      end
      S_DACC: begin
        cmd.op    = mi4_pkg::OP_DACC;
        cmd.neg   = dcol[0];
        cmd.first = (dcol == 2'd0);
        if (dcol == 2'd3) begin
          state_next = S_DFIN;
        end else begin
          dcol_next  = dcol + 2'd1;
          state_next = S_MINOR;
        end
      end
      S_DFIN: begin
        cmd.op     = mi4_pkg::OP_DFIN;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        det_mode_next = 1'b0;
        if (status.det_zero) begin
          kidx_next  = 4'd15;
          state_next = S_SING;
        end else begin
          kidx_next  = 4'd0;
          state_next = S_MINOR;
        end
      end
      S_DIV: begin
        cmd.op     = mi4_pkg::OP_DIV;
        cmd.neg    = kidx[0] ^ kidx[2];
        cmd.last   = (kidx == 4'd15);
        state_next = S_OUTW;
      end
      S_SING: begin
        cmd.op     = mi4_pkg::OP_SING;
        state_next = S_OUTW;
      end
      S_OUTW: begin
        if (status.out_done) begin
          if (kidx == 4'd15) begin
            state_next = S_LOAD;
          end else begin
            kidx_next  = kidx + 4'd1;
            state_next = S_MINOR;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      load_cnt <= '0;
      term     <= '0;
      step     <= '0;
      dcol     <= '0;
      kidx     <= '0;
      det_mode <= 1'b0;
    end else begin
      state    <= state_next;
      load_cnt <= load_cnt_next;
      term     <= term_next;
      step     <= step_next;
      dcol     <= dcol_next;
      kidx     <= kidx_next;
      det_mode <= det_mode_next;
    end
  end

endmodule

`default_nettype wire

// File: src/mi4_datapath.sv
// ----------------------------------------------------------------------------
// mi4_datapath
// element ram, multiply-accumulate, determinant and bit-serial divider
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_inverse_4x4_unit_defines.svh"

module mi4_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire mi4_pkg::cmd_t                   cmd,
  input  wire logic [mi4_pkg::ELEM_WIDTH-1:0]  s_tdata,
  output mi4_pkg::status_t                     status,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [mi4_pkg::ELEM_WIDTH-1:0]  m_tdata,
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  logic [mi4_pkg::ELEM_WIDTH-1:0] ram_rdata;
  mi4_pkg::cmd_t                  cmd_d;

  mi4_ram #(
    .WIDTH (mi4_pkg::ELEM_WIDTH),
    .DEPTH (16)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (cmd.waddr),
    .wdata (s_tdata),
    .raddr (cmd.raddr),
    .rdata (ram_rdata)
  );

  logic signed [mi4_pkg::ELEM_WIDTH-1:0] elem;
  logic signed [mi4_pkg::PROD_W-1:0]     prod;
  logic signed [mi4_pkg::PROD_W-1:0]     prod_mul;
  logic signed [mi4_pkg::MINOR_W-1:0]    minor;
  logic signed [mi4_pkg::MINOR_W-1:0]    prod_ext;
  logic signed [mi4_pkg::DPROD_W-1:0]    dprod;
  logic signed [mi4_pkg::DET_W-1:0]      det;
  logic signed [mi4_pkg::DET_W-1:0]      dprod_ext;
  logic signed [mi4_pkg::DET_W-1:0]      det_abs;
  logic        [mi4_pkg::MAG_W-1:0]      det_mag;
  logic                                  det_neg;
  logic                                  det_zero;
  logic signed [mi4_pkg::MINOR_W:0]      cof;
  logic        [mi4_pkg::MINOR_W:0]      cof_mag;

  logic [mi4_pkg::NUM_W-1:0] num;
  logic [mi4_pkg::DEN_W-1:0] den;
  logic [mi4_pkg::DEN_W-1:0] rem;
  logic [mi4_pkg::NUM_W-1:0] r2;
  logic [mi4_pkg::NUM_W-1:0] r2_sub;
  logic                      ge;
  logic [mi4_pkg::Q_W-1:0]   q;
  logic                      ovf;
  logic                      qneg;
  logic                      qlast;
  logic [mi4_pkg::CNT_W-1:0] cnt;
  logic                      div_busy;
  logic                      div_fin;
  logic [mi4_pkg::Q_W-1:0]   limit;
  logic [mi4_pkg::Q_W-1:0]   qsat;
  logic [mi4_pkg::Q_W-1:0]   qout;

  logic                           out_valid;
  logic [mi4_pkg::ELEM_WIDTH-1:0] out_data;
  logic                           out_sing;
  logic                           out_last;

  always_comb begin
    elem      = $signed(ram_rdata);
    prod_mul  = $signed(prod[2*mi4_pkg::ELEM_WIDTH-1:0]) * elem;
    prod_ext  = mi4_pkg::MINOR_W'(prod);
    dprod_ext = mi4_pkg::DET_W'(dprod);
    det_abs   = det[mi4_pkg::DET_W-1] ? -det : det;
    cof       = cmd_d.neg ? -(mi4_pkg::MINOR_W+1)'(minor) : (mi4_pkg::MINOR_W+1)'(minor);
    cof_mag   = cof[mi4_pkg::MINOR_W] ? $unsigned(-cof) : $unsigned(cof);
    r2        = {rem, num[mi4_pkg::NUM_W-1]};
    r2_sub    = r2 - {1'b0, den};
    ge        = (r2 >= {1'b0, den});
    // magnitude limit: one step further on the negative side
    limit     = (mi4_pkg::Q_W'(1) << (mi4_pkg::ELEM_WIDTH - 1)) - mi4_pkg::Q_W'(!qneg);
    qsat      = (ovf || (q > limit)) ? limit : q;
    qout      = qneg ? -qsat : qsat;
  end

  // arithmetic ops are delayed by one register to line up with the registered ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_d.op <= mi4_pkg::OP_NOP;
    end else begin
      cmd_d.op <= cmd.op;
    end
    cmd_d.raddr <= cmd.raddr;
    cmd_d.we    <= 1'b0;
    cmd_d.waddr <= cmd.waddr;
    cmd_d.neg   <= cmd.neg;
    cmd_d.first <= cmd.first;
    cmd_d.last  <= cmd.last;
  end

  always_ff @(posedge clk) begin
    unique case (cmd_d.op)
      mi4_pkg::OP_FIRST: prod <= mi4_pkg::PROD_W'(elem);
      mi4_pkg::OP_MUL:   prod <= prod_mul;
      mi4_pkg::OP_ACC: begin
        if (cmd_d.first) begin
          minor <= cmd_d.neg ? -prod_ext : prod_ext;
        end else begin
          minor <= cmd_d.neg ? minor - prod_ext : minor + prod_ext;
        end
      end
      mi4_pkg::OP_DMUL:  dprod <= minor * elem;
      mi4_pkg::OP_DACC: begin
        if (cmd_d.first) begin
          det <= cmd_d.neg ? -dprod_ext : dprod_ext;
        end else begin
          det <= cmd_d.neg ? det - dprod_ext : det + dprod_ext;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      det_neg  <= 1'b0;
      det_mag  <= '0;
      det_zero <= 1'b1;
    end else if (cmd_d.op == mi4_pkg::OP_DFIN) begin
      det_neg  <= det[mi4_pkg::DET_W-1];
      det_mag  <= det_abs[mi4_pkg::MAG_W-1:0];
      det_zero <= (det_abs[mi4_pkg::MAG_W-1:0] == '0);
    end
  end

  // restoring division of (2*|cof|*2^16 + |det|) by 2*|det|, one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_fin  <= 1'b0;
      cnt      <= '0;
    end else begin
      div_fin <= 1'b0;
      if (cmd_d.op == mi4_pkg::OP_DIV) begin
        div_busy <= 1'b1;
        cnt      <= '0;
      end else if (div_busy) begin
        cnt <= cnt + mi4_pkg::CNT_W'(1);
        if (cnt == mi4_pkg::CNT_W'(mi4_pkg::DIV_STEPS - 1)) begin
          div_busy <= 1'b0;
          div_fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_d.op == mi4_pkg::OP_DIV) begin
      num   <= {1'b0, cof_mag[mi4_pkg::PROD_W-1:0], {mi4_pkg::SHIFT{1'b0}}}
               + {2'b00, det_mag};
      den   <= {det_mag, 1'b0};
      rem   <= '0;
      q     <= '0;
      ovf   <= 1'b0;
      qneg  <= cof[mi4_pkg::MINOR_W] ^ det_neg;
      qlast <= cmd_d.last;
    end else if (div_busy) begin
      num <= {num[mi4_pkg::NUM_W-2:0], 1'b0};
      rem <= ge ? r2_sub[mi4_pkg::DEN_W-1:0] : r2[mi4_pkg::DEN_W-1:0];
      ovf <= ovf | q[mi4_pkg::Q_W-1];
      q   <= {q[mi4_pkg::Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_fin || (cmd_d.op == mi4_pkg::OP_SING)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_fin) begin
      out_data <= qout[mi4_pkg::ELEM_WIDTH-1:0];
      out_sing <= 1'b0;
      out_last <= qlast;
    end else if (cmd_d.op == mi4_pkg::OP_SING) begin
      out_data <= '0;
      out_sing <= 1'b1;
      out_last <= 1'b1;
    end
  end

  assign m_tvalid        = out_valid;
  assign m_tdata         = out_data;
  assign m_tuser         = out_sing;
  assign m_tlast         = out_last;
  assign status.det_zero = det_zero;
  assign status.out_done = out_valid & m_tready;

  `MI4_ASSERT_IMPL(a_sing_frame, clk, rst, out_valid && out_sing, out_last && (out_data == '0))
  `MI4_ASSERT_IMPL(a_div_quiet, clk, rst, div_busy, !out_valid)
  `MI4_ASSERT_NEXT(a_fin_shows, clk, rst, div_fin, out_valid && !out_sing)

endmodule

`default_nettype wire

// File: src/matrix_inverse_4x4_unit.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_unit
// 4x4 signed q8.8 matrix inverse by adjugate over stream interfaces
// ----------------------------------------------------------------------------
// Sixteen elements are taken row-major, one per transfer, while the block is
// loading. It then expands the determinant on the first row and emits
// either one singular-flagged result or the sixteen inverse elements
// row-major, the last marked with tlast. Each inverse element takes, with
// the receiver ready, a 3x3 cofactor through one element ram read port and
// one multiplier, a start of the divide, the one-bit-per-cycle divider,
// which sets the pace, and the loading and presenting of the result. No
// element is accepted until the last result has been transferred.
`default_nettype none

module matrix_inverse_4x4_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [mi4_pkg::ELEM_WIDTH-1:0] s_tdata,   // elem_value
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [mi4_pkg::ELEM_WIDTH-1:0] m_tdata,   // inv_value
  output logic                                m_tuser,   // singular
  output logic                                m_tlast
);

  mi4_pkg::cmd_t    cmd;
  mi4_pkg::status_t status;

  mi4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mi4_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
